@@ src/thermal_fan_hysteresis_monitor_defines.svh @@
// Assertion macros shared by the fan hysteresis monitor RTL
`ifndef THERMAL_FAN_HYSTERESIS_MONITOR_DEFINES_SVH
`define THERMAL_FAN_HYSTERESIS_MONITOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define THFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thfm same-cycle check failed");

// Next-cycle implication, checked outside reset
`define THFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thfm next-cycle check failed");

`endif

@@ src/thfm_pkg.sv @@
// Package: payload types, register indexes and defaults of the fan hysteresis monitor
`timescale 1ns / 1ps

package thfm_pkg;

    localparam int MAX_MOTORS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TEMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT  = 2'd2;

    localparam logic [7:0] TRIGGER_TEMP_RST = 8'd60;
    localparam logic [7:0] RELEASE_TEMP_RST = 8'd50;
    localparam logic [4:0] MOTOR_COUNT_RST  = 5'd0;

    localparam logic [2:0] FANS_ALL_ON = 3'b111;

    typedef struct packed {
        logic [3:0] motor_slot;
        logic [7:0] reading;
        logic       read_ok;
        logic [2:0] fans_now;
    } t_item_in;

    typedef struct packed {
        logic [2:0] fan_drive;
        logic       fan_write;
        logic       overheat_flag;
    } t_item_out;

endpackage

@@ src/thfm_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module thfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/thermal_fan_hysteresis_monitor.sv @@
// Top level: over-temperature fan control with hysteresis over a per-motor table
`timescale 1ns / 1ps
//
//  channel   direction  handshake           payload
//  --------  ---------  ------------------  ---------------------------------
//  item in   input      i_valid / o_ready   i_item  (slot, reading, ok, fans)
//  result    output     o_valid / i_ready   o_item  (drive, write, overheat)
//  config    input      i_cfg_we            i_cfg_idx, i_cfg_wdata
//
//  Flow: an accepted item is stored, then the shared comparator walks the
//  table, one entry per cycle through the registered RAM read port, folds in
//  the last read and closes; the result is then registered and the next
//  item is taken once the block is back in idle.
//  Reset: synchronous, active low; the table reads as zero after reset through
//  per-entry valid bits, so no clearing pass is needed.
//  Stalls: a pending result holds in the output register; the block finishes
//  the next item's walk but holds its decision until that result is taken.
//
`include "thermal_fan_hysteresis_monitor_defines.svh"

module thermal_fan_hysteresis_monitor
    import thfm_pkg::*;
#(
    parameter int MAX_MOTORS = MAX_MOTORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item in
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item_in              i_item,
    // result out
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_item_out             o_item,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Table address width and a count width that can hold MAX_MOTORS itself
    localparam int IW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int CW = $clog2(MAX_MOTORS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STORE,
        S_WALK,
        S_DONE
    } t_state;

    t_state            r_state;

    // Configuration registers
    logic [7:0]        r_trigger_temp;
    logic [7:0]        r_release_temp;
    logic [4:0]        r_motor_count;

    // Captured item and walk state
    t_item_in          r_item;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic              r_rd_vld;
    logic              r_hit;

    // Hysteresis state
    logic              r_overheat;
    logic [2:0]        r_saved_fans;
    logic [MAX_MOTORS-1:0] r_valid;

    // Result register
    logic              r_out_valid;
    t_item_out         r_out;

    logic [CW-1:0]     used_cnt;
    logic              store_en;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        entry;
    logic [8:0]        cmp_thr;
    logic              cmp_ge;
    logic              issue;
    logic              out_free;

    // Clamp the motor count to the table depth
    assign used_cnt = (32'(r_motor_count) > MAX_MOTORS) ? CW'(MAX_MOTORS)
                                                        : CW'(r_motor_count);

    // Store only a good reading for a slot in use
    assign store_en = (r_state == S_STORE) && r_item.read_ok
                      && (32'(r_item.motor_slot) < 32'(r_used));
    assign wr_addr  = IW'(r_item.motor_slot);

    assign issue   = (r_state == S_WALK) && (r_idx < r_used);
    assign rd_addr = r_idx[IW-1:0];

    thfm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MOTORS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (store_en),
        .i_waddr (wr_addr),
        .i_wdata (r_item.reading),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Shared comparator: while cool, hunt for any entry at or above trigger;
    // while overheating, hunt for any entry above release (threshold release+1)
    assign entry   = r_rd_vld ? rd_data : 8'd0;
    assign cmp_thr = r_overheat ? ({1'b0, r_release_temp} + 9'd1)
                                : {1'b0, r_trigger_temp};
    assign cmp_ge  = {1'b0, entry} >= cmp_thr;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_trigger_temp <= TRIGGER_TEMP_RST;
            r_release_temp <= RELEASE_TEMP_RST;
            r_motor_count  <= MOTOR_COUNT_RST;
            r_overheat     <= 1'b0;
            r_saved_fans   <= 3'd0;
            r_valid        <= '0;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_hit          <= 1'b0;
            r_idx          <= '0;
            r_used         <= '0;
        end else begin
            // Configuration writes; unknown indexes are dropped
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TRIGGER_TEMP: r_trigger_temp <= i_cfg_wdata;
                    REG_RELEASE_TEMP: r_release_temp <= i_cfg_wdata;
                    REG_MOTOR_COUNT:  r_motor_count  <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end

            // Raise the result flag on a decision, drop it once the transfer completes
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item  <= i_item;
                        r_used  <= used_cnt;
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (store_en) begin
                        r_valid[wr_addr] <= 1'b1;
                    end
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_hit   <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // Fold in the entry read last cycle
                    if (r_pend && cmp_ge) begin
                        r_hit <= 1'b1;
                    end
                    if (issue) begin
                        r_rd_vld <= r_valid[rd_addr];
                        r_idx    <= r_idx + CW'(1);
                        r_pend   <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // Hold the decision until the output register is free
                    if (out_free) begin
                        if (!r_overheat && r_hit) begin
                            r_saved_fans <= r_item.fans_now;
                            r_overheat   <= 1'b1;
                            r_out        <= '{fan_drive: FANS_ALL_ON, fan_write: 1'b1,
                                              overheat_flag: 1'b1};
                        end else if (r_overheat && !r_hit) begin
                            r_overheat <= 1'b0;
                            r_out      <= '{fan_drive: r_saved_fans, fan_write: 1'b1,
                                            overheat_flag: 1'b0};
                        end else begin
                            r_out <= '{fan_drive: 3'd0, fan_write: 1'b0,
                                       overheat_flag: r_overheat};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // The walk never runs past the clamped count
    `THFM_ASSERT_NOW(a_idx_bound, i_clk, i_rst_n, r_state == S_WALK, r_idx <= r_used)
    // An accepted item starts the store step and drops ready
    `THFM_ASSERT_NEXT(a_accept_store, i_clk, i_rst_n, i_valid && o_ready,
        (r_state == S_STORE) && !o_ready)
    // Entering overheat always drives every fan on
    `THFM_ASSERT_NOW(a_trip_all_on, i_clk, i_rst_n,
        o_valid && o_item.fan_write && o_item.overheat_flag, o_item.fan_drive == FANS_ALL_ON)
    // A result without a fan change carries a zero drive
    `THFM_ASSERT_NOW(a_idle_drive, i_clk, i_rst_n, o_valid && !o_item.fan_write,
        o_item.fan_drive == 3'd0)
    // Outside the decision state, a result reports the overheat state held
    `THFM_ASSERT_NOW(a_flag_match, i_clk, i_rst_n, o_valid && (r_state != S_DONE),
        o_item.overheat_flag == r_overheat)

endmodule
